/* rtl/sirc_pkg.sv */
`timescale 1ns / 1ps

package sirc_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SEND   = 2'd1,
        OP_REPEAT = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START_ON  = 3'd1,
        PH_START_OFF = 3'd2,
        PH_BIT_ON    = 3'd3,
        PH_BIT_OFF   = 3'd4,
        PH_GAP       = 3'd5
    } phase_t;

    localparam int CodeWidth     = 24;
    localparam int CountWidth    = 5;
    localparam int GapWidth      = 8;
    localparam int DurWidth      = 7;
    localparam int InDataWidth   = 24;
    localparam int OutDataWidth  = 16;

    localparam logic [DurWidth-1:0] LenStart = 7'd96;
    localparam logic [DurWidth-1:0] LenZero  = 7'd24;
    localparam logic [DurWidth-1:0] LenOne   = 7'd48;
    localparam logic [DurWidth-1:0] LenSpace = 7'd24;

    localparam logic [GapWidth-1:0] GapDefault = 8'd45;

    localparam logic [CountWidth-1:0] FrameLen20 = 5'd20;
    localparam logic [CountWidth-1:0] FrameLen15 = 5'd15;
    localparam logic [CountWidth-1:0] FrameLen12 = 5'd12;

    localparam int FlagBit20 = 23;
    localparam int FlagBit15 = 15;

    function automatic logic [CountWidth-1:0] frame_len(input logic [CodeWidth-1:0] code);
        logic [CountWidth-1:0] len;
        if (code[FlagBit20])
            len = FrameLen20;
        else if (code[FlagBit15])
            len = FrameLen15;
        else
            len = FrameLen12;
        return len;
    endfunction

endpackage

/* rtl/sirc_ir_frame_encoder.sv */
`timescale 1ns / 1ps
// An accepted input word is held in the input register, and its result word then in the result register.
// Throughput: one word per cycle while m_tready keeps up; an input register and a result register separate the sides.
// The sequencer update is a single pass of combinational logic between those two registers.
// Reset (rst_n low, asynchronous): sequencer idle, stored code cleared, frame length 12,
// gap_ticks back to 45, both registers empty.
module sirc_ir_frame_encoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sirc_pkg::GapWidth-1:0]       cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sirc_pkg::InDataWidth-1:0]    s_tdata,  // [23:0] code
    input  logic [1:0]                          s_tuser,  // [1:0] operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sirc_pkg::OutDataWidth-1:0]   m_tdata   // [0] carrier_on, [7:1] duration,
                                                          // [8] busy_res, [9] frame_started
);

    logic                               in_valid_reg;
    sirc_pkg::op_t                      in_op_reg;
    logic [sirc_pkg::CodeWidth-1:0]     in_code_reg;

    logic                               out_valid_reg;
    logic                               out_carrier_reg;
    logic [sirc_pkg::DurWidth-1:0]      out_dur_reg;
    logic                               out_busy_reg;
    logic                               out_started_reg;

    logic [sirc_pkg::GapWidth-1:0]      gap_ticks_reg;

    sirc_pkg::phase_t                   phase_reg, phase_next;
    logic [sirc_pkg::CodeWidth-1:0]     stored_code_reg, stored_code_next;
    logic [sirc_pkg::CodeWidth-1:0]     shift_bits_reg, shift_bits_next;
    logic [sirc_pkg::CountWidth-1:0]    frame_length_reg, frame_length_next;
    logic [sirc_pkg::CountWidth-1:0]    bits_sent_reg, bits_sent_next;
    logic [sirc_pkg::GapWidth-1:0]      gap_count_reg, gap_count_next;
    logic                               level_reg, level_next;
    logic [sirc_pkg::DurWidth-1:0]      last_dur_reg, last_dur_next;

    logic                               adv;
    logic                               fire;
    logic                               started;
    logic [sirc_pkg::CountWidth-1:0]    bits_inc;
    logic [sirc_pkg::GapWidth-1:0]      gap_inc;

    assign adv      = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;
    assign bits_inc = bits_sent_reg + 5'd1;
    assign gap_inc  = gap_count_reg + 8'd1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_started_reg, out_busy_reg, out_dur_reg, out_carrier_reg};

    // sequencer
    always_comb
    begin
        phase_next        = phase_reg;
        stored_code_next  = stored_code_reg;
        shift_bits_next   = shift_bits_reg;
        frame_length_next = frame_length_reg;
        bits_sent_next    = bits_sent_reg;
        gap_count_next    = gap_count_reg;
        level_next        = level_reg;
        last_dur_next     = last_dur_reg;
        started           = 1'b0;
        if (fire)
        begin
            case (in_op_reg)
                sirc_pkg::OP_TICK:
                begin
                    case (phase_reg)
                        sirc_pkg::PH_START_ON:
                        begin
                            level_next    = 1'b1;
                            last_dur_next = sirc_pkg::LenStart;
                            phase_next    = sirc_pkg::PH_START_OFF;
                        end
                        sirc_pkg::PH_START_OFF:
                        begin
                            level_next    = 1'b0;
                            last_dur_next = sirc_pkg::LenSpace;
                            phase_next    = sirc_pkg::PH_BIT_ON;
                        end
                        sirc_pkg::PH_BIT_ON:
                        begin
                            level_next      = 1'b1;
                            last_dur_next   = shift_bits_reg[0] ? sirc_pkg::LenOne
                                                                : sirc_pkg::LenZero;
                            shift_bits_next = {1'b0, shift_bits_reg[sirc_pkg::CodeWidth-1:1]};
                            phase_next      = sirc_pkg::PH_BIT_OFF;
                        end
                        sirc_pkg::PH_BIT_OFF:
                        begin
                            level_next     = 1'b0;
                            last_dur_next  = sirc_pkg::LenSpace;
                            bits_sent_next = bits_inc;
                            phase_next     = (bits_inc >= frame_length_reg) ? sirc_pkg::PH_GAP
                                                                            : sirc_pkg::PH_BIT_ON;
                        end
                        sirc_pkg::PH_GAP:
                        begin
                            level_next     = 1'b0;
                            last_dur_next  = sirc_pkg::LenSpace;
                            gap_count_next = gap_inc;
                            if (gap_inc >= gap_ticks_reg)
                            begin
                                bits_sent_next = '0;
                                gap_count_next = '0;
                                phase_next     = sirc_pkg::PH_IDLE;
                            end
                        end
                        default:
                        begin
                            level_next = 1'b0;
                            phase_next = sirc_pkg::PH_IDLE;
                        end
                    endcase
                end
                sirc_pkg::OP_SEND:
                begin
                    stored_code_next  = in_code_reg;
                    frame_length_next = sirc_pkg::frame_len(in_code_reg);
                    if (in_code_reg != '0 && phase_reg == sirc_pkg::PH_IDLE)
                    begin
                        shift_bits_next = in_code_reg;
                        phase_next      = sirc_pkg::PH_START_ON;
                        started         = 1'b1;
                    end
                end
                sirc_pkg::OP_REPEAT:
                begin
                    if (stored_code_reg != '0 && phase_reg == sirc_pkg::PH_IDLE)
                    begin
                        shift_bits_next = stored_code_reg;
                        phase_next      = sirc_pkg::PH_START_ON;
                        started         = 1'b1;
                    end
                end
                sirc_pkg::OP_STOP:
                begin
                    stored_code_next = '0;
                end
                default:
                begin
                    stored_code_next = stored_code_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= sirc_pkg::PH_IDLE;
            stored_code_reg  <= '0;
            shift_bits_reg   <= '0;
            frame_length_reg <= sirc_pkg::FrameLen12;
            bits_sent_reg    <= '0;
            gap_count_reg    <= '0;
            level_reg        <= 1'b0;
            last_dur_reg     <= '0;
            gap_ticks_reg    <= sirc_pkg::GapDefault;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            stored_code_reg  <= stored_code_next;
            shift_bits_reg   <= shift_bits_next;
            frame_length_reg <= frame_length_next;
            bits_sent_reg    <= bits_sent_next;
            gap_count_reg    <= gap_count_next;
            level_reg        <= level_next;
            last_dur_reg     <= last_dur_next;
            if (cfg_we)
                gap_ticks_reg <= cfg_wdata;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= sirc_pkg::op_t'(s_tuser);
            in_code_reg <= s_tdata;
        end
        if (fire)
        begin
            out_carrier_reg <= level_next;
            out_dur_reg     <= last_dur_next;
            out_busy_reg    <= (phase_next != sirc_pkg::PH_IDLE);
            out_started_reg <= started;
        end
    end

    a_started_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_started_reg) |-> out_busy_reg)
        else $error("frame start reported without busy");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sirc_pkg::PH_IDLE) |-> (bits_sent_reg == '0 && gap_count_reg == '0))
        else $error("counters not cleared in idle");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_sent_reg <= sirc_pkg::FrameLen20)
        else $error("bit count beyond longest frame");

    a_level_phase: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg |-> (phase_reg == sirc_pkg::PH_START_OFF || phase_reg == sirc_pkg::PH_BIT_OFF))
        else $error("carrier on outside a burst");

    a_fire_moves: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed word did not reach result register");

endmodule

/* bench/tb_sirc_ir_frame_encoder.sv */
`timescale 1ns / 1ps

module tb_sirc_ir_frame_encoder;

    localparam int HalfPeriod     = 2;
    localparam int ResetCycles    = 6;
    localparam int WatchdogLimit  = 5000;
    localparam int HoldCycles     = 400;
    localparam int RandomPerPhase = 600;

    typedef struct packed {
        sirc_pkg::op_t                  op;
        logic [sirc_pkg::CodeWidth-1:0] code;
    } ir_cmd_t;

    typedef struct packed {
        logic                          carrier;
        logic [sirc_pkg::DurWidth-1:0] duration;
        logic                          busy;
        logic                          started;
    } segment_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [sirc_pkg::GapWidth-1:0]     cfg_wdata = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [sirc_pkg::InDataWidth-1:0]  s_tdata   = '0;
    logic [1:0]                        s_tuser   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [sirc_pkg::OutDataWidth-1:0] m_tdata;

    // encoder state mirror
    sirc_pkg::phase_t                  enc_phase;
    logic [sirc_pkg::CodeWidth-1:0]    enc_code;
    logic [sirc_pkg::CodeWidth-1:0]    enc_shift;
    logic [sirc_pkg::CountWidth-1:0]   enc_len;
    logic [sirc_pkg::CountWidth-1:0]   enc_bits;
    logic [sirc_pkg::GapWidth-1:0]     enc_gap_cnt;
    logic [sirc_pkg::GapWidth-1:0]     enc_gap_limit;
    logic                              enc_level;
    logic [sirc_pkg::DurWidth-1:0]     enc_dur;

    ir_cmd_t  cmd_queue[$];
    segment_t segment_queue[$];
    ir_cmd_t  taken_cmd;
    ir_cmd_t  next_cmd;
    segment_t got;
    segment_t want;

    int   cmds_issued      = 0;
    int   segments_checked = 0;
    int   fail_count       = 0;
    int   quiet_cycles     = 0;
    int   send_gap_pct     = 0;
    int   recv_gap_pct     = 0;
    int   hold_req         = 0;
    int   hold_seen        = 0;
    int   hold_left        = 0;
    logic in_fire          = 1'b0;
    logic out_fire;

    always #HalfPeriod clk = ~clk;

    sirc_ir_frame_encoder DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    function automatic logic [sirc_pkg::CodeWidth-1:0] rand_code();
        logic [31:0] r;
        r = $urandom();
        return r[sirc_pkg::CodeWidth-1:0];
    endfunction

    function automatic void reset_encoder();
        enc_phase     = sirc_pkg::PH_IDLE;
        enc_code      = '0;
        enc_shift     = '0;
        enc_len       = sirc_pkg::FrameLen12;
        enc_bits      = '0;
        enc_gap_cnt   = '0;
        enc_gap_limit = sirc_pkg::GapDefault;
        enc_level     = 1'b0;
        enc_dur       = '0;
    endfunction

    function automatic void advance_sequencer();
        case (enc_phase)
            sirc_pkg::PH_START_ON:
            begin
                enc_level = 1'b1;
                enc_dur   = sirc_pkg::LenStart;
                enc_phase = sirc_pkg::PH_START_OFF;
            end
            sirc_pkg::PH_START_OFF:
            begin
                enc_level = 1'b0;
                enc_dur   = sirc_pkg::LenSpace;
                enc_phase = sirc_pkg::PH_BIT_ON;
            end
            sirc_pkg::PH_BIT_ON:
            begin
                enc_level = 1'b1;
                enc_dur   = enc_shift[0] ? sirc_pkg::LenOne : sirc_pkg::LenZero;
                enc_shift = enc_shift >> 1;
                enc_phase = sirc_pkg::PH_BIT_OFF;
            end
            sirc_pkg::PH_BIT_OFF:
            begin
                enc_level = 1'b0;
                enc_dur   = sirc_pkg::LenSpace;
                enc_bits  = enc_bits + 5'd1;
                enc_phase = (enc_bits >= enc_len) ? sirc_pkg::PH_GAP : sirc_pkg::PH_BIT_ON;
            end
            sirc_pkg::PH_GAP:
            begin
                enc_level   = 1'b0;
                enc_dur     = sirc_pkg::LenSpace;
                enc_gap_cnt = enc_gap_cnt + 8'd1;
                if (enc_gap_cnt >= enc_gap_limit)
                begin
                    enc_bits    = '0;
                    enc_gap_cnt = '0;
                    enc_phase   = sirc_pkg::PH_IDLE;
                end
            end
            default:
            begin
                enc_level = 1'b0;
                enc_phase = sirc_pkg::PH_IDLE;
            end
        endcase
    endfunction

    function automatic logic try_frame();
        if (enc_code != '0 && enc_phase == sirc_pkg::PH_IDLE)
        begin
            enc_shift = enc_code;
            enc_phase = sirc_pkg::PH_START_ON;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic segment_t predict_segment(ir_cmd_t cmd);
        segment_t seg;
        seg.started = 1'b0;
        case (cmd.op)
            sirc_pkg::OP_TICK:
                advance_sequencer();
            sirc_pkg::OP_SEND:
            begin
                enc_code = cmd.code;
                if (cmd.code[sirc_pkg::FlagBit20])
                    enc_len = sirc_pkg::FrameLen20;
                else if (cmd.code[sirc_pkg::FlagBit15])
                    enc_len = sirc_pkg::FrameLen15;
                else
                    enc_len = sirc_pkg::FrameLen12;
                seg.started = try_frame();
            end
            sirc_pkg::OP_REPEAT:
                seg.started = try_frame();
            default:
                enc_code = '0;
        endcase
        seg.carrier  = enc_level;
        seg.duration = enc_dur;
        seg.busy     = (enc_phase != sirc_pkg::PH_IDLE);
        return seg;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_fire = m_tvalid && m_tready;
            if (cfg_we)
                enc_gap_limit = cfg_wdata;
            if (out_fire)
            begin
                got = {m_tdata[0], m_tdata[7:1], m_tdata[8], m_tdata[9]};
                if (segment_queue.size() == 0)
                begin
                    $error("unexpected result word %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = segment_queue.pop_front();
                    segments_checked++;
                    if (got.carrier !== want.carrier)
                    begin
                        $error("carrier_on: expected %0d, actual %0d", want.carrier, got.carrier);
                        fail_count++;
                    end
                    if (got.duration !== want.duration)
                    begin
                        $error("duration: expected %0d, actual %0d", want.duration, got.duration);
                        fail_count++;
                    end
                    if (got.busy !== want.busy)
                    begin
                        $error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
                        fail_count++;
                    end
                    if (got.started !== want.started)
                    begin
                        $error("frame_started: expected %0d, actual %0d",
                               want.started, got.started);
                        fail_count++;
                    end
                end
            end
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                taken_cmd.op   = sirc_pkg::op_t'(s_tuser);
                taken_cmd.code = s_tdata;
                segment_queue.push_back(predict_segment(taken_cmd));
            end
            if (out_fire || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_gap_pct)
            begin
                next_cmd = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_cmd.op;
                s_tdata  <= next_cmd.code;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HoldCycles;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    task automatic queue_cmd(input sirc_pkg::op_t op, input logic [sirc_pkg::CodeWidth-1:0] code);
        ir_cmd_t cmd;
        cmd.op   = op;
        cmd.code = code;
        cmd_queue.push_back(cmd);
        cmds_issued++;
    endtask

    task automatic wait_drain();
        while (segments_checked != cmds_issued)
            @(negedge clk);
    endtask

    // tick the sequencer back to idle so that the gap register changes between frames
    task automatic settle();
        wait_drain();
        while (enc_phase != sirc_pkg::PH_IDLE)
        begin
            queue_cmd(sirc_pkg::OP_TICK, rand_code());
            wait_drain();
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_gap(input logic [sirc_pkg::GapWidth-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        int                             pick;
        logic [sirc_pkg::CodeWidth-1:0] code;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            code = rand_code();
            if (pick < 72)
                queue_cmd(sirc_pkg::OP_TICK, code);
            else if (pick < 86)
            begin
                if ($urandom_range(19) == 0)
                    code = '0;
                queue_cmd(sirc_pkg::OP_SEND, code);
            end
            else if (pick < 93)
                queue_cmd(sirc_pkg::OP_REPEAT, code);
            else
                queue_cmd(sirc_pkg::OP_STOP, code);
        end
    endtask

    initial
    begin
        reset_encoder();
        send_gap_pct = 27;
        recv_gap_pct = 62;
        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_gap(8'd0);
        queue_cmd(sirc_pkg::OP_TICK, '0);
        queue_cmd(sirc_pkg::OP_REPEAT, '0);
        queue_cmd(sirc_pkg::OP_SEND, '0);
        queue_cmd(sirc_pkg::OP_STOP, 24'hFFFFFF);
        queue_cmd(sirc_pkg::OP_SEND, 24'hFFFFFF);
        queue_cmd(sirc_pkg::OP_REPEAT, 24'hFFFFFF);
        repeat (4) queue_cmd(sirc_pkg::OP_TICK, '0);
        queue_cmd(sirc_pkg::OP_SEND, 24'h000123);
        queue_cmd(sirc_pkg::OP_STOP, '0);
        repeat (3) queue_cmd(sirc_pkg::OP_TICK, 24'hFFFFFF);
        settle();
        queue_cmd(sirc_pkg::OP_SEND, 24'h00A5A5);
        repeat (8) queue_cmd(sirc_pkg::OP_TICK, '0);
        settle();

        write_gap(8'd1);
        queue_random(RandomPerPhase);
        settle();

        send_gap_pct = 62;
        recv_gap_pct = 27;
        write_gap(8'd255);
        send_gap_pct = 0;
        hold_req++;
        queue_random(RandomPerPhase);
        repeat (HoldCycles) @(negedge clk);
        send_gap_pct = 62;
        settle();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_gap(sirc_pkg::GapDefault);
        queue_random(RandomPerPhase);
        settle();

        repeat (10) @(negedge clk);
        if (fail_count == 0 && segment_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
